// File: src/interleaved_bitmap_attribute_renderer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for interleaved_bitmap_attribute_renderer_core
// Concurrent checks with a common clock and report form.
// ----------------------------------------------------------------------------
`ifndef INTERLEAVED_BITMAP_ATTRIBUTE_RENDERER_CORE_MACROS_SVH
`define INTERLEAVED_BITMAP_ATTRIBUTE_RENDERER_CORE_MACROS_SVH

// check that is off while reset is asserted
`define IBAR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds during reset
`define IBAR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ibar_pkg.sv
// ----------------------------------------------------------------------------
// ibar_pkg
// Types, constants and helpers shared by the bitmap/attribute renderer.
// ----------------------------------------------------------------------------
package ibar_pkg;

    localparam int STORE_BYTES = 6912;
    localparam int ADDR_W      = 13;

    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_addr      ATT_BASE     = t_addr'(6144);
    localparam logic [7:0] DISPLAY_ROWS = 8'd192;
    localparam logic [7:0] COLOR_LEVEL  = 8'hfd;
    localparam t_addr      LAST_ADDR    = t_addr'(STORE_BYTES - 1);

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [12:0] screen_offset;
        logic [7:0]  write_byte;
        logic [7:0]  row;
        logic [4:0]  column;
    } t_in;

    typedef struct packed {
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [23:0] pixel_color;
        logic        last_pixel;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_BMP,
        ST_RD_ATT,
        ST_LOAD,
        ST_SHIFT
    } t_state;

    // sequencer -> serializer
    typedef struct packed {
        logic load;
    } t_shf_ctrl;

    // serializer -> sequencer
    typedef struct packed {
        logic active;
        logic last;
    } t_shf_stat;

    // 3-bit index to 24-bit color: bit0 -> [23:16], bit2 -> [15:8], bit1 -> [7:0]
    function automatic logic [23:0] map_color(input logic [2:0] idx);
        logic [23:0] c;
        c = {(idx[0] ? COLOR_LEVEL : 8'h00),
             (idx[2] ? COLOR_LEVEL : 8'h00),
             (idx[1] ? COLOR_LEVEL : 8'h00)};
        return c;
    endfunction

endpackage

// File: src/ibar_store.sv
// ----------------------------------------------------------------------------
// ibar_store
// Screen store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ibar_store (
    input  logic           i_clk,
    input  logic           i_we,
    input  ibar_pkg::t_addr i_waddr,
    input  logic [7:0]     i_wdata,
    input  ibar_pkg::t_addr i_raddr,
    output logic [7:0]     o_rdata
);
    import ibar_pkg::*;

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ibar_shifter.sv
// ----------------------------------------------------------------------------
// ibar_shifter
// Pixel serializer: shifts the bitmap byte out MSB first, one pixel a cycle.
// ----------------------------------------------------------------------------
module ibar_shifter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ibar_pkg::t_shf_ctrl i_ctrl,
    input  logic [7:0]          i_bits,
    input  logic [7:0]          i_attr,
    input  logic [7:0]          i_row,
    input  logic [4:0]          i_col,
    output ibar_pkg::t_shf_stat o_stat,
    output logic                o_strobe,
    output ibar_pkg::t_out      o_result
);
    import ibar_pkg::*;

    logic       r_active;
    logic [2:0] r_cnt;
    logic [7:0] r_bits;
    logic [2:0] r_ink;
    logic [2:0] r_paper;
    logic [7:0] r_row;
    logic [4:0] r_col;
    logic       r_strobe;
    t_out       r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= 3'd0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (i_ctrl.load) begin
                r_active <= 1'b1;
                r_cnt    <= 3'd0;
            end else if (r_active) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_bits  <= i_bits;
            r_ink   <= i_attr[2:0];
            r_paper <= i_attr[5:3];
            r_row   <= i_row;
            r_col   <= i_col;
        end else if (r_active) begin
            r_bits               <= {r_bits[6:0], 1'b0};
            r_result.pixel_x     <= {r_col, r_cnt};
            r_result.pixel_y     <= r_row;
            r_result.pixel_color <= r_bits[7] ? map_color(r_ink) : map_color(r_paper);
            r_result.last_pixel  <= (r_cnt == 3'd7);
        end
    end

    assign o_stat.active = r_active;
    assign o_stat.last   = r_active && (r_cnt == 3'd7);
    assign o_strobe      = r_strobe;
    assign o_result      = r_result;

endmodule

// File: src/interleaved_bitmap_attribute_renderer_core.sv
// Write: taken while idle, busy stays low; out-of-range offsets are dropped.
// Render: bitmap byte read, attribute byte read, serializer load, then eight
// pixels on consecutive cycles; busy stays high until the last bit shifts.
// Out-of-display rows give no pixels and leave the core idle.
// Reset clears the 6912-byte store one byte a cycle, busy high until done.
// Pixels cannot be stalled; the single store read port sets the fetch time.
`include "interleaved_bitmap_attribute_renderer_core_macros.svh"

// ----------------------------------------------------------------------------
// interleaved_bitmap_attribute_renderer_core
// Interleaved bitmap/attribute screen store with an eight-pixel cell renderer.
// ----------------------------------------------------------------------------
module interleaved_bitmap_attribute_renderer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ibar_pkg::t_in  i_req,
    output logic           o_busy,
    output logic           o_strobe,
    output ibar_pkg::t_out o_result
);
    import ibar_pkg::*;

    t_state     r_state, n_state;
    t_addr      r_clr_addr, n_clr_addr;
    logic [7:0] r_row;
    logic [4:0] r_col;
    logic [7:0] r_bmp;

    logic       mem_we;
    t_addr      mem_waddr;
    logic [7:0] mem_wdata;
    t_addr      mem_raddr;
    logic [7:0] mem_rdata;

    t_shf_ctrl  shf_ctrl;
    t_shf_stat  shf_stat;
    logic       accept;
    t_addr      bmp_addr;
    t_addr      att_addr;

    assign accept = i_start && !o_busy;

    // bitmap row: swap row fields 2:0 and 5:3
    assign bmp_addr = {r_row[7:6], r_row[2:0], r_row[5:3], r_col};
    assign att_addr = ATT_BASE + t_addr'({r_row[7:3], r_col});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row <= i_req.row;
            r_col <= i_req.column;
        end
        if (r_state == ST_RD_ATT) begin
            r_bmp <= mem_rdata;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        mem_we        = 1'b0;
        mem_waddr     = i_req.screen_offset;
        mem_wdata     = i_req.write_byte;
        mem_raddr     = bmp_addr;
        shf_ctrl.load = 1'b0;
        o_busy        = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = 8'h00;
                n_clr_addr = r_clr_addr + t_addr'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_req.req_type == REQ_WRITE) begin
                        mem_we = (i_req.screen_offset < t_addr'(STORE_BYTES));
                    end else if (i_req.row < DISPLAY_ROWS) begin
                        n_state = ST_RD_BMP;
                    end
                end
            end
            ST_RD_BMP: begin
                mem_raddr = bmp_addr;
                n_state   = ST_RD_ATT;
            end
            ST_RD_ATT: begin
                mem_raddr = att_addr;
                n_state   = ST_LOAD;
            end
            ST_LOAD: begin
                shf_ctrl.load = 1'b1;
                n_state       = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (shf_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    ibar_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ibar_shifter u_shifter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (shf_ctrl),
        .i_bits   (r_bmp),
        .i_attr   (mem_rdata),
        .i_row    (r_row),
        .i_col    (r_col),
        .o_stat   (shf_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    `IBAR_ASSERT(a_no_pixel_in_clear, i_clk, i_rst_n,
        (r_state == ST_CLEAR) |-> !o_strobe, "pixel strobe during store clear")
    `IBAR_ASSERT(a_last_at_end, i_clk, i_rst_n,
        (o_strobe && o_result.last_pixel) |-> (o_result.pixel_x[2:0] == 3'd7),
        "last pixel flag not on eighth pixel")
    `IBAR_ASSERT(a_burst_unbroken, i_clk, i_rst_n,
        (o_strobe && !o_result.last_pixel) |=> o_strobe, "pixel burst broken")
    `IBAR_ASSERT(a_busy_in_burst, i_clk, i_rst_n,
        (o_strobe && !o_result.last_pixel) |-> o_busy, "new transfer possible mid-burst")
    `IBAR_ASSERT_ALWAYS(a_shift_needs_state, i_clk,
        shf_stat.active |-> (r_state == ST_SHIFT), "serializer running outside shift state")

endmodule

// File: tb/sv/interleaved_bitmap_attribute_renderer_core_tb.sv
// ----------------------------------------------------------------------------
// interleaved_bitmap_attribute_renderer_core_tb
// Self-checking bench for the screen store and cell renderer. A directed
// table covers the store edges, the palette and the dropped requests. A long
// run of writes and renders follows, mostly aimed at a small set of cells so
// that renders see written data. Each pixel is compared against a local
// model of the store or, for typed table rows, a color given in the table.
// ----------------------------------------------------------------------------
module interleaved_bitmap_attribute_renderer_core_tb;
    import ibar_pkg::*;

    localparam int RANDOM_ITEMS = 185;
    localparam int IDLE_LIMIT   = 30000;  // covers the clear pass after reset
    localparam int MAX_GAP      = 40;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_OFFSET   = 8191;

    typedef struct {
        t_in         req;
        bit          typed;   // use color below instead of the screen model
        logic [23:0] color;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_in  i_req;
    logic o_busy;
    logic o_strobe;
    t_out o_result;

    logic [7:0] screen_mem [0:STORE_BYTES-1];
    t_out       pixel_q [$];

    int n_err       = 0;
    int n_pix       = 0;
    int n_writes    = 0;
    int n_renders   = 0;
    int n_dropped   = 0;
    int idle_cycles = 0;

    interleaved_bitmap_attribute_renderer_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [23:0] palette_rgb(input logic [2:0] idx);
        logic [23:0] c;
        c = '0;
        if (idx[0]) c[23:16] = COLOR_LEVEL;
        if (idx[1]) c[7:0]   = COLOR_LEVEL;
        if (idx[2]) c[15:8]  = COLOR_LEVEL;
        return c;
    endfunction

    // line bits 5:3 and 2:0 trade places in the bitmap address
    function automatic int bitmap_addr(input logic [7:0] row, input logic [4:0] col);
        logic [7:0] sh;
        sh = {row[7:6], row[2:0], row[5:3]};
        return int'({sh, col});
    endfunction

    function automatic int attr_addr(input logic [7:0] row, input logic [4:0] col);
        return int'(ATT_BASE) + int'(row[7:3]) * 32 + int'(col);
    endfunction

    function automatic t_in make_req(input logic kind, input int off, input int wbyte,
                                     input int row, input int col);
        t_in r;
        r.req_type      = kind;
        r.screen_offset = 13'(off);
        r.write_byte    = 8'(wbyte);
        r.row           = 8'(row);
        r.column        = 5'(col);
        return r;
    endfunction

    task automatic push_cell(input logic [7:0] row, input logic [4:0] col,
                             input logic [7:0] bits, input logic [23:0] ink,
                             input logic [23:0] paper);
        t_out p;
        for (int k = 0; k < 8; k++) begin
            p.pixel_x     = {col, 3'(k)};
            p.pixel_y     = row;
            p.pixel_color = bits[7-k] ? ink : paper;
            p.last_pixel  = (k == 7);
            pixel_q.push_back(p);
        end
    endtask

    task automatic predict_item(input t_in r);
        logic [7:0] attr;
        if (r.req_type == REQ_WRITE) begin
            n_writes++;
            if (int'(r.screen_offset) < STORE_BYTES)
                screen_mem[int'(r.screen_offset)] = r.write_byte;
            else
                n_dropped++;
        end else begin
            n_renders++;
            if (r.row >= DISPLAY_ROWS) begin
                n_dropped++;
            end else begin
                attr = screen_mem[attr_addr(r.row, r.column)];
                push_cell(r.row, r.column, screen_mem[bitmap_addr(r.row, r.column)],
                          palette_rgb(attr[2:0]), palette_rgb(attr[5:3]));
            end
        end
    endtask

    // raise start after an optional idle gap, hold it until the transfer
    task automatic send_item(input t_row cmd, input int gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= cmd.req;
        do @(posedge i_clk); while (o_busy);
        if (cmd.typed) begin
            n_renders++;
            push_cell(cmd.req.row, cmd.req.column, 8'h00, 24'h000000, cmd.color);
        end else begin
            predict_item(cmd.req);
        end
    endtask

    // outputs are stable mid-cycle; sampling here keeps clear of the driver
    always @(negedge i_clk) begin
        t_out want;
        if (i_rst_n && o_strobe) begin
            if (pixel_q.size() == 0) begin
                $error("pixel with nothing pending: x=%0d y=%0d",
                       o_result.pixel_x, o_result.pixel_y);
                n_err++;
            end else begin
                want = pixel_q.pop_front();
                n_pix++;
                if (o_result.pixel_x !== want.pixel_x) begin
                    $error("pixel_x: expected %0d, got %0d", want.pixel_x, o_result.pixel_x);
                    n_err++;
                end
                if (o_result.pixel_y !== want.pixel_y) begin
                    $error("pixel_y: expected %0d, got %0d", want.pixel_y, o_result.pixel_y);
                    n_err++;
                end
                if (o_result.pixel_color !== want.pixel_color) begin
                    $error("pixel_color: expected %06h, got %06h",
                           want.pixel_color, o_result.pixel_color);
                    n_err++;
                end
                if (o_result.last_pixel !== want.last_pixel) begin
                    $error("last_pixel: expected %0b, got %0b",
                           want.last_pixel, o_result.last_pixel);
                    n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_row dir_tab [$];
        t_row item;
        int   pct_tab [4];
        int   counted, pct, gap, pick, sel, off, hot_row, hot_col, row, col;

        // receiver cannot stall, so its phases leave the sender as is
        pct_tab = '{0, 70, 0, 10};
        foreach (screen_mem[i]) screen_mem[i] = 8'h00;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_req   <= '0;

        // row 10 column 5 sits at bitmap byte 549, attribute byte 6181
        dir_tab = '{
            '{make_req(REQ_RENDER, 0, 0, 0, 0),          1'b1, 24'h000000},
            '{make_req(REQ_RENDER, 0, 0, 191, 31),       1'b1, 24'h000000},
            '{make_req(REQ_RENDER, 0, 0, 192, 0),        1'b0, 24'h000000},
            '{make_req(REQ_RENDER, 8191, 255, 255, 31),  1'b0, 24'h000000},
            '{make_req(REQ_WRITE, 0, 8'hff, 0, 0),       1'b0, 24'h000000},
            '{make_req(REQ_WRITE, 6144, 8'h07, 0, 0),    1'b0, 24'h000000},
            '{make_req(REQ_RENDER, 0, 0, 0, 0),          1'b1, 24'hfdfdfd},
            '{make_req(REQ_WRITE, 6911, 8'hc1, 0, 0),    1'b0, 24'h000000},
            '{make_req(REQ_RENDER, 0, 0, 191, 31),       1'b1, 24'h000000},
            '{make_req(REQ_WRITE, 6143, 8'ha5, 0, 0),    1'b0, 24'h000000},
            '{make_req(REQ_RENDER, 0, 0, 191, 31),       1'b0, 24'h000000},
            '{make_req(REQ_WRITE, 6912, 8'h55, 0, 0),    1'b0, 24'h000000},
            '{make_req(REQ_WRITE, 8191, 8'hff, 255, 31), 1'b0, 24'h000000},
            '{make_req(REQ_RENDER, 0, 0, 0, 0),          1'b1, 24'hfdfdfd},
            '{make_req(REQ_WRITE, 6144, 8'h38, 0, 0),    1'b0, 24'h000000},
            '{make_req(REQ_RENDER, 0, 0, 0, 0),          1'b1, 24'h000000},
            '{make_req(REQ_WRITE, 549, 8'h96, 0, 0),     1'b0, 24'h000000},
            '{make_req(REQ_WRITE, 6181, 8'h2b, 0, 0),    1'b0, 24'h000000},
            '{make_req(REQ_RENDER, 0, 0, 10, 5),         1'b0, 24'h000000},
            '{make_req(REQ_WRITE, 6181, 8'h14, 0, 0),    1'b0, 24'h000000},
            '{make_req(REQ_RENDER, 0, 0, 10, 5),         1'b0, 24'h000000},
            '{make_req(REQ_WRITE, 6181, 8'h0e, 0, 0),    1'b0, 24'h000000},
            '{make_req(REQ_RENDER, 0, 0, 10, 5),         1'b0, 24'h000000},
            '{make_req(REQ_WRITE, 6181, 8'hd5, 0, 0),    1'b0, 24'h000000},
            '{make_req(REQ_RENDER, 0, 0, 10, 5),         1'b0, 24'h000000}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) send_item(dir_tab[i], 0);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pct = pct_tab[counted * 4 / RANDOM_ITEMS];
            gap = 0;
            while (gap < MAX_GAP && $urandom_range(99) < pct) gap++;

            // hot cells: top and bottom lines, first four columns
            hot_row = $urandom_range(23);
            if (hot_row >= 16) hot_row += 168;
            hot_col = $urandom_range(3);
            pick = $urandom_range(99);
            sel  = $urandom_range(99);
            if (pick < 45) begin
                if (sel < 40)
                    off = bitmap_addr(8'(hot_row), 5'(hot_col));
                else if (sel < 65)
                    off = attr_addr(8'(hot_row), 5'(hot_col));
                else if (sel < 90)
                    off = $urandom_range(STORE_BYTES - 1);
                else
                    off = $urandom_range(MAX_OFFSET, STORE_BYTES);
                item.req = make_req(REQ_WRITE, off, $urandom_range(255),
                                    $urandom_range(255), $urandom_range(31));
            end else begin
                if (sel < 75) begin
                    row = hot_row;
                    col = hot_col;
                end else if (sel < 90) begin
                    row = $urandom_range(191);
                    col = $urandom_range(31);
                end else begin
                    row = $urandom_range(255, 192);
                    col = $urandom_range(31);
                end
                item.req = make_req(REQ_RENDER, $urandom_range(MAX_OFFSET),
                                    $urandom_range(255), row, col);
            end
            item.typed = 1'b0;
            item.color = 24'h000000;
            send_item(item, gap);
            counted++;
        end
        i_start <= 1'b0;

        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pixel_q.size() != 0) begin
            $error("%0d expected pixels never arrived", pixel_q.size());
            n_err++;
        end
        $display("ran %0d writes and %0d renders (%0d dropped as out of range)",
                 n_writes, n_renders, n_dropped);
        $display("compared %0d pixels, %0d mismatches", n_pix, n_err);
        if (n_err == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: interleaved_bitmap_attribute_renderer_core.f
+incdir+src
src/ibar_pkg.sv
src/ibar_store.sv
src/ibar_shifter.sv
src/interleaved_bitmap_attribute_renderer_core.sv
tb/sv/interleaved_bitmap_attribute_renderer_core_tb.sv
